### src/ppdr_pkg.sv
// shared types, constants and arctangent table for the planar pose integrator
`default_nettype none
package ppdr_pkg;

  typedef logic signed [31:0] pos_t;
  typedef logic        [31:0] angle_t;
  typedef logic signed [15:0] speed_t;
  typedef logic        [15:0] step_t;

  localparam int CORDIC_ITERS = 16;
  localparam int ATAN_ENTRIES = 24;
  // iterations actually run: capped by the table length
  localparam int ITER_COUNT = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;
  localparam int ITER_W = $clog2(ATAN_ENTRIES);

  // cordic datapath width: Q2.30 plus headroom
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cord_t;

  // start vector: 1/gain in Q2.30
  localparam logic [31:0] CORDIC_X0 = 32'h26DD_3B6A;
  localparam logic [31:0] QUARTER_HALF = 32'h2000_0000;

  // arctangent of 2^-i in binary-angle units
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // register indexes of the configuration port
  localparam logic REG_STEP_TIME = 1'b0;
  localparam logic REG_HOLONOMIC = 1'b1;

endpackage
`default_nettype wire

### src/ppdr_in_if.sv
// input channel: velocity step with optional start pose
`default_nettype none
interface ppdr_in_if;
  logic              valid;
  logic              ready;
  logic              start_req;
  ppdr_pkg::pos_t    init_x;
  ppdr_pkg::pos_t    init_y;
  ppdr_pkg::angle_t  init_heading;
  ppdr_pkg::speed_t  vel_forward;
  ppdr_pkg::speed_t  vel_lateral;
  ppdr_pkg::speed_t  turn_rate;

  modport source (output valid, start_req, init_x, init_y, init_heading,
                  output vel_forward, vel_lateral, turn_rate, input ready);
  modport sink   (input valid, start_req, init_x, init_y, init_heading,
                  input vel_forward, vel_lateral, turn_rate, output ready);
endinterface
`default_nettype wire

### src/ppdr_out_if.sv
// output channel: pose after one step
`default_nettype none
interface ppdr_out_if;
  logic              valid;
  logic              ready;
  ppdr_pkg::pos_t    pos_x;
  ppdr_pkg::pos_t    pos_y;
  ppdr_pkg::angle_t  heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface
`default_nettype wire

### src/planar_pose_dead_reckoning.sv
// top level: planar pose integrator with iterative cordic and shared multiplier
//
//   channel   dir   payload                                          handshake
//   in_ch     in    start_req, init_x/y, init_heading, vel_*, turn   valid/ready
//   out_ch    out   pos_x, pos_y, heading                            valid/ready
//   cfg       in    cfg_index (1 bit), cfg_data (16 bit)             cfg_we only
//
// a step runs the cordic loop on a shared add/shift unit, then a rounding state
// that also forms the heading step on the single shared multiplier, then the
// multiply states S_MX1..S_MY3 on that multiplier; a new transfer is taken
// only once the sequencer is back in idle, after the last step has left S_MY3
// in_ch.ready is high only while the sequencer is idle
// a finished pose waits in the output register; the next step may already run
// and only stalls in its last cycle if the previous pose is still untaken
// reset (synchronous, rst high) clears the pose to zero and loads the default
// step time and differential mode
`default_nettype none
module planar_pose_dead_reckoning (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  ppdr_in_if.sink          in_ch,
  ppdr_out_if.source       out_ch
);

  localparam int CW = ppdr_pkg::CW;
  localparam int IW = ppdr_pkg::ITER_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ITER  = 4'd1;
  localparam logic [3:0] S_ROUND = 4'd2;
  localparam logic [3:0] S_MX1   = 4'd3;
  localparam logic [3:0] S_MX2   = 4'd4;
  localparam logic [3:0] S_MX3   = 4'd5;
  localparam logic [3:0] S_MY1   = 4'd6;
  localparam logic [3:0] S_MY2   = 4'd7;
  localparam logic [3:0] S_MY3   = 4'd8;

  localparam logic [IW-1:0] LAST_ITER = IW'(ppdr_pkg::ITER_COUNT - 1);

  // configuration
  ppdr_pkg::step_t   step_time;
  logic              holonomic_mode;

  // pose state
  ppdr_pkg::pos_t    acc_x;
  ppdr_pkg::pos_t    acc_y;
  ppdr_pkg::angle_t  acc_heading;

  // latched step inputs
  ppdr_pkg::speed_t  vf;
  ppdr_pkg::speed_t  vl;
  ppdr_pkg::speed_t  w;

  // cordic registers
  ppdr_pkg::cord_t   cx;
  ppdr_pkg::cord_t   cy;
  ppdr_pkg::cord_t   cz;
  logic [1:0]        quad;
  logic [IW-1:0]     iter;

  // trig results in Q1.14, heading delta and velocity accumulator
  logic signed [15:0] cos_q;
  logic signed [15:0] sin_q;
  ppdr_pkg::angle_t   head_delta;
  ppdr_pkg::cord_t    dv;

  logic [3:0]         state;

  // output register
  logic               out_valid;
  ppdr_pkg::pos_t     out_x;
  ppdr_pkg::pos_t     out_y;
  ppdr_pkg::angle_t   out_heading;

  logic in_xfer;
  logic out_free;
  logic pose_load;
  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  // last step cycle with room in the output register
  assign pose_load   = (state == S_MY3) && out_free;

  assign out_ch.valid   = out_valid;
  assign out_ch.pos_x   = out_x;
  assign out_ch.pos_y   = out_y;
  assign out_ch.heading = out_heading;

  // heading before the step and its quadrant split
  ppdr_pkg::angle_t start_ang;
  ppdr_pkg::angle_t shifted_ang;
  assign start_ang   = in_ch.start_req ? in_ch.init_heading : acc_heading;
  assign shifted_ang = start_ang + ppdr_pkg::QUARTER_HALF;

  // shared cordic add/shift unit
  ppdr_pkg::cord_t sh_x;
  ppdr_pkg::cord_t sh_y;
  ppdr_pkg::cord_t atan_val;
  assign sh_x     = cx >>> iter;
  assign sh_y     = cy >>> iter;
  assign atan_val = CW'({2'b00, ppdr_pkg::ATAN_TAB[iter]});

  // rounding to Q1.14 with clamp, then quadrant rotation
  ppdr_pkg::cord_t     cx_rnd;
  ppdr_pkg::cord_t     cy_rnd;
  logic signed [17:0]  c_full;
  logic signed [17:0]  s_full;
  logic signed [15:0]  c_clip;
  logic signed [15:0]  s_clip;
  logic signed [15:0]  cos_next;
  logic signed [15:0]  sin_next;

  assign cx_rnd = cx + CW'(32768);
  assign cy_rnd = cy + CW'(32768);
  assign c_full = cx_rnd[CW-1:16];
  assign s_full = cy_rnd[CW-1:16];

  always_comb begin
    if (c_full > 18'sd16384) begin
      c_clip = 16'sd16384;
    end else if (c_full < -18'sd16384) begin
      c_clip = -16'sd16384;
    end else begin
      c_clip = c_full[15:0];
    end
    if (s_full > 18'sd16384) begin
      s_clip = 16'sd16384;
    end else if (s_full < -18'sd16384) begin
      s_clip = -16'sd16384;
    end else begin
      s_clip = s_full[15:0];
    end
    case (quad)
      2'd0: begin
        cos_next = c_clip;
        sin_next = s_clip;
      end
      2'd1: begin
        cos_next = -s_clip;
        sin_next = c_clip;
      end
      2'd2: begin
        cos_next = -c_clip;
        sin_next = -s_clip;
      end
      default: begin
        cos_next = s_clip;
        sin_next = -c_clip;
      end
    endcase
  end

  // shared multiplier, operands chosen by the sequencer
  logic signed [CW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic signed [51:0]   prod;
  logic signed [51:0]   prod_rnd;
  ppdr_pkg::pos_t       step_dist;
  logic signed [17:0]   dt_s;

  assign dt_s = $signed({2'b00, step_time});

  always_comb begin
    case (state)
      S_ROUND: begin
        mul_a = CW'(w);
        mul_b = dt_s;
      end
      S_MX1: begin
        mul_a = CW'(vf);
        mul_b = 18'(cos_q);
      end
      S_MX2: begin
        mul_a = CW'(vl);
        mul_b = 18'(sin_q);
      end
      S_MY1: begin
        mul_a = CW'(vf);
        mul_b = 18'(sin_q);
      end
      S_MY2: begin
        mul_a = CW'(vl);
        mul_b = 18'(cos_q);
      end
      S_MX3, S_MY3: begin
        mul_a = dv;
        mul_b = dt_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = 52'(mul_a * mul_b);
  // 2^-42 m to 2^-16 m, round half up
  assign prod_rnd  = prod + 52'sd33554432;
  assign step_dist = 32'({{6{prod_rnd[51]}}, prod_rnd[51:26]});

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time      <= 16'd3277;
      holonomic_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppdr_pkg::REG_STEP_TIME: step_time      <= cfg_data;
        ppdr_pkg::REG_HOLONOMIC: holonomic_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer and pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      out_valid   <= 1'b0;
      iter        <= '0;
    end else begin
      // pose register: loaded on completion, cleared once taken
      out_valid <= pose_load || (out_valid && !out_ch.ready);
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.start_req) begin
              acc_x       <= in_ch.init_x;
              acc_y       <= in_ch.init_y;
              acc_heading <= in_ch.init_heading;
            end
            iter  <= '0;
            state <= S_ITER;
          end
        end
        S_ITER: begin
          iter <= iter + 1'b1;
          if (iter == LAST_ITER) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: state <= S_MX1;
        S_MX1:   state <= S_MX2;
        S_MX2:   state <= S_MX3;
        S_MX3: begin
          acc_x <= acc_x + step_dist;
          state <= S_MY1;
        end
        S_MY1:   state <= S_MY2;
        S_MY2:   state <= S_MY3;
        S_MY3: begin
          // hold here while the previous pose is still waiting
          if (out_free) begin
            acc_y       <= acc_y + step_dist;
            acc_heading <= acc_heading + head_delta;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          vf   <= in_ch.vel_forward;
          vl   <= holonomic_mode ? in_ch.vel_lateral : 16'sd0;
          w    <= in_ch.turn_rate;
          quad <= shifted_ang[31:30];
          cx   <= CW'($signed({2'b00, ppdr_pkg::CORDIC_X0}));
          cy   <= '0;
          cz   <= CW'($signed({2'b00, shifted_ang[29:0]}))
                  - CW'($signed({2'b00, ppdr_pkg::QUARTER_HALF}));
        end
      end
      S_ITER: begin
        // rotate toward zero residual angle
        if (!cz[CW-1]) begin
          cx <= cx - sh_y;
          cy <= cy + sh_x;
          cz <= cz - atan_val;
        end else begin
          cx <= cx + sh_y;
          cy <= cy - sh_x;
          cz <= cz + atan_val;
        end
      end
      S_ROUND: begin
        cos_q      <= cos_next;
        sin_q      <= sin_next;
        // heading step is 2 * turn_rate * step_time, wrapping
        head_delta <= {prod[30:0], 1'b0};
      end
      S_MX1, S_MY1: dv <= prod[CW-1:0];
      S_MX2:        dv <= dv - prod[CW-1:0];
      S_MY2:        dv <= dv + prod[CW-1:0];
      S_MY3: begin
        if (out_free) begin
          out_x       <= acc_x;
          out_y       <= acc_y + step_dist;
          out_heading <= acc_heading + head_delta;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### bench/planar_pose_dead_reckoning_tb.sv
// self-checking bench for the planar pose integrator: directed and random steps, scoreboarded
module planar_pose_dead_reckoning_tb;
  import ppdr_pkg::*;

  // step item as offered on the input channel
  typedef struct {
    logic   start_req;
    pos_t   init_x;
    pos_t   init_y;
    angle_t init_heading;
    speed_t vel_forward;
    speed_t vel_lateral;
    speed_t turn_rate;
  } step_item_t;

  // pose as returned on the output channel
  typedef struct {
    pos_t   x;
    pos_t   y;
    angle_t hd;
  } pose_t;

  // rotations actually applied by the bench's own sine/cosine unit
  localparam int TRIG_TABLE_LEN = 24;
  localparam int TRIG_STEPS     = (16 < TRIG_TABLE_LEN) ? 16 : TRIG_TABLE_LEN;
  localparam longint ROUND_HALF = 64'sd33554432;   // half an lsb of the 2^-26 shift
  localparam longint START_X    = 64'sh26DD3B6A;   // inverse cordic gain, q2.30
  localparam longint Q14_ONE    = 64'sd16384;
  localparam longint RESIDUAL_OFS = 64'sd536870912;
  // idle cycles with no transfer on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 3000;
  // receiver hold-off long enough to fill the block and stall its input
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned HOLD_OFF_AT     = 60;
  // tail after the last pose, about one step of the block
  localparam int unsigned TAIL_CYCLES = 30;

  // arctangent of 2^-i, binary angle
  localparam logic [31:0] ARCTAN [TRIG_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  ppdr_in_if  in_ch ();
  ppdr_out_if out_ch ();

  planar_pose_dead_reckoning dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk = ~clk;

  // bench copy of the block's registers and integrated pose
  step_t  dt_setting    = 16'd3277;
  logic   holo_setting  = 1'b0;
  pos_t   track_x       = '0;
  pos_t   track_y       = '0;
  angle_t track_heading = '0;

  step_item_t pending_steps [$];   // queued by the stimulus, not yet offered
  pose_t      poses_due [$];       // predicted poses awaiting their transfer
  step_item_t offered;             // item currently on the input channel

  int unsigned mismatches = 0;
  int unsigned poses_seen = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // cosine and sine of a binary angle in q1.14: fold into the quadrant nearest
  // to zero, rotate the residual, round, clamp, then unfold
  function automatic void cordic_cos_sin(input angle_t ang, output longint cos_q,
                                         output longint sin_q);
    angle_t      shifted;
    logic [1:0]  quad;
    longint      z, x, y, dx, dy, c, s;
    shifted = ang + 32'h2000_0000;
    quad    = shifted[31:30];
    z       = longint'(shifted[29:0]) - RESIDUAL_OFS;
    x       = START_X;
    y       = 0;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ARCTAN[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ARCTAN[i]);
      end
    end
    c = (x + 64'sd32768) >>> 16;
    s = (y + 64'sd32768) >>> 16;
    if (c > Q14_ONE) c = Q14_ONE;
    if (c < -Q14_ONE) c = -Q14_ONE;
    if (s > Q14_ONE) s = Q14_ONE;
    if (s < -Q14_ONE) s = -Q14_ONE;
    case (quad)
      2'd0: begin cos_q = c;  sin_q = s;  end
      2'd1: begin cos_q = -s; sin_q = c;  end
      2'd2: begin cos_q = -c; sin_q = -s; end
      default: begin cos_q = s; sin_q = -c; end
    endcase
  endfunction

  // velocity (2^-26 m/s) times step (2^-16 s) to 2^-16 m, round half up, wrapped
  function automatic logic [31:0] rate_to_displacement(input longint rate, input longint dt);
    longint d;
    d = (rate * dt + ROUND_HALF) >>> 26;
    return d[31:0];
  endfunction

  // one step of the integrator on the bench's own pose
  function automatic pose_t advance_pose(input step_item_t it);
    longint vf, vl, w, dt, c, s, hd_step;
    pose_t  p;
    if (it.start_req) begin
      track_x       = it.init_x;
      track_y       = it.init_y;
      track_heading = it.init_heading;
    end
    vf = longint'(it.vel_forward);
    // differential drive: no sideways motion; holonomic mode keeps the lateral speed
    vl = holo_setting ? longint'(it.vel_lateral) : 64'sd0;
    w  = longint'(it.turn_rate);
    dt = longint'(dt_setting);
    // rotation uses the heading held before this step
    cordic_cos_sin(track_heading, c, s);
    track_x       = track_x + rate_to_displacement(vf * c - vl * s, dt);
    track_y       = track_y + rate_to_displacement(vf * s + vl * c, dt);
    hd_step       = 2 * w * dt;
    track_heading = track_heading + hd_step[31:0];
    p.x  = track_x;
    p.y  = track_y;
    p.hd = track_heading;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle stretch: mostly short, now and then long
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  // speeds and turn rates: extremes, small values and anything at all
  function automatic speed_t pick_speed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'sh8000;
    if (r < 16) return 16'sh7FFF;
    if (r < 20) return '0;
    if (r < 50) return speed_t'($urandom_range(0, 4000)) - 16'sd2000;
    return speed_t'($urandom);
  endfunction

  // headings: sometimes within two lsb of a multiple of an eighth turn, otherwise anywhere
  function automatic angle_t pick_heading();
    if ($urandom_range(0, 99) < 25)
      return {3'($urandom_range(0, 7)), 29'd0} + angle_t'($urandom_range(0, 4)) - 32'd2;
    return angle_t'($urandom);
  endfunction

  // init fields are always random; the block must ignore them without a start
  function automatic step_item_t random_step(input logic start);
    step_item_t it;
    it.start_req    = start;
    it.init_x       = pos_t'($urandom);
    it.init_y       = pos_t'($urandom);
    it.init_heading = pick_heading();
    it.vel_forward  = pick_speed();
    it.vel_lateral  = pick_speed();
    it.turn_rate    = pick_speed();
    return it;
  endfunction

  function automatic void queue_step(input logic start, input pos_t ix, input pos_t iy,
                                     input angle_t ih, input speed_t vf, input speed_t vl,
                                     input speed_t w);
    step_item_t it;
    it.start_req    = start;
    it.init_x       = ix;
    it.init_y       = iy;
    it.init_heading = ih;
    it.vel_forward  = vf;
    it.vel_lateral  = vl;
    it.turn_rate    = w;
    pending_steps.push_back(it);
  endfunction

  // register write while the block is idle; bench copy follows at once
  task automatic program_register(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_STEP_TIME) dt_setting = data;
    else holo_setting = data[0];
  endtask

  // sender pause: nothing queued, nothing offered, every pose returned
  task automatic wait_drained();
    while (pending_steps.size() != 0 || in_ch.valid || poses_due.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one nonblocking update of valid per edge, fed from pending_steps
  // ---------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;   // stretch with no sender gaps

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      // transfer at this edge: predict from the item that was on the channel
      if (in_ch.valid && in_ch.ready) begin
        poses_due.push_back(advance_pose(offered));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          offered = pending_steps.pop_front();
          in_ch.start_req    <= offered.start_req;
          in_ch.init_x       <= offered.init_x;
          in_ch.init_y       <= offered.init_y;
          in_ch.init_heading <= offered.init_heading;
          in_ch.vel_forward  <= offered.vel_forward;
          in_ch.vel_lateral  <= offered.vel_lateral;
          in_ch.turn_rate    <= offered.turn_rate;
          in_ch.valid        <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          // gap applies once this item has gone
          if (!send_calm && $urandom_range(0, 2) == 0) send_gap = idle_length();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each returned pose against the oldest prediction
  // ---------------------------------------------------------------------------
  int unsigned recv_stall = 0;
  int unsigned hold_left  = 0;
  bit          held_off   = 1'b0;
  bit          recv_calm  = 1'b0;   // stretch with ready held high
  pose_t       want;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        poses_seen++;
        if (poses_due.size() == 0) begin
          $display("%0t: unexpected pose, actual x %h y %h heading %h", $time,
                   out_ch.pos_x, out_ch.pos_y, out_ch.heading);
          mismatches++;
        end else begin
          want = poses_due.pop_front();
          if (out_ch.pos_x !== want.x) begin
            $display("%0t: pos_x mismatch, expected %h, actual %h", $time, want.x,
                     out_ch.pos_x);
            mismatches++;
          end
          if (out_ch.pos_y !== want.y) begin
            $display("%0t: pos_y mismatch, expected %h, actual %h", $time, want.y,
                     out_ch.pos_y);
            mismatches++;
          end
          if (out_ch.heading !== want.hd) begin
            $display("%0t: heading mismatch, expected %h, actual %h", $time, want.hd,
                     out_ch.heading);
            mismatches++;
          end
        end
      end
      // one long hold-off in the first random phase: the output register and
      // the step behind it fill, so the input must stall while items are offered
      if (!held_off && poses_seen == HOLD_OFF_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
        if (!recv_calm && $urandom_range(0, 3) == 0) recv_stall = idle_length();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: run abandoned after too long without any transfer
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("planar_pose_dead_reckoning_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned queued;
    step_t       dt_pick;
    logic        holo_pick;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_STEP_TIME;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.start_req    = 1'b0;
    in_ch.init_x       = '0;
    in_ch.init_y       = '0;
    in_ch.init_heading = '0;
    in_ch.vel_forward  = '0;
    in_ch.vel_lateral  = '0;
    in_ch.turn_rate    = '0;
    out_ch.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings, differential: first step before any start integrates
    // from the zero pose; lateral speed must have no effect
    queue_step(1'b0, 32'sd5, -32'sd5, 32'h1234_5678, 16'sh7FFF, 16'sh7FFF, '0);
    queue_step(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0000_0000,
               16'sh7FFF, 16'sh8000, 16'sh7FFF);
    queue_step(1'b1, -32'sd1, '0, 32'h2000_0000, 16'sh8000, '0, 16'sh8000);
    queue_step(1'b1, '0, '0, 32'h1FFF_FFFF, 16'sd1000, 16'sd1000, 16'sd1);
    queue_step(1'b1, '0, '0, 32'h4000_0000, 16'sh7FFF, '0, -16'sd1);
    queue_step(1'b1, '0, '0, 32'h8000_0000, 16'sh7FFF, '0, '0);
    queue_step(1'b1, '0, '0, 32'hC000_0000, 16'sh7FFF, '0, '0);
    queue_step(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
               16'sh8000, 16'sh8000, 16'sh8000);
    queue_step(1'b1, '0, '0, 32'hE000_0000, 16'sh7FFF, '0, 16'sh7FFF);
    queue_step(1'b0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0);
    wait_drained();

    // longest step, holonomic: full lateral contribution
    program_register(REG_STEP_TIME, 16'hFFFF);
    program_register(REG_HOLONOMIC, 16'h0001);
    queue_step(1'b1, '0, '0, '0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_step(1'b0, '0, '0, '0, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_step(1'b1, '0, '0, 32'h6000_0000, 16'sh7FFF, 16'sh8000, 16'sd1);
    queue_step(1'b1, '0, '0, 32'hA000_0000, 16'sh8000, 16'sh7FFF, -16'sd1);
    queue_step(1'b0, '0, '0, '0, 16'sd12345, -16'sd23456, 16'sd16384);
    wait_drained();

    // zero step time: pose must stay where the start put it
    program_register(REG_STEP_TIME, 16'h0000);
    queue_step(1'b1, 32'sd123456, -32'sd654321, 32'h1234_5678,
               16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_step(1'b0, '0, '0, '0, 16'sh8000, 16'sh8000, 16'sh8000);
    wait_drained();

    // shortest step, back to differential, upper data bits set
    program_register(REG_STEP_TIME, 16'h0001);
    program_register(REG_HOLONOMIC, 16'hFFFE);
    queue_step(1'b1, '0, '0, 32'h9000_0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    queue_step(1'b0, '0, '0, '0, 16'sh8000, 16'sh7FFF, 16'sh8000);
    queue_step(1'b0, '0, '0, '0, 16'sd777, -16'sd777, 16'sd2);
    wait_drained();

    // random trajectories: a start then a run of plain steps, under
    // several settings with the extremes among them
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin dt_pick = step_t'($urandom_range(1, 65535)); holo_pick = 1'b1; end
        1:       begin dt_pick = 16'hFFFF; holo_pick = 1'b0; end
        2:       begin dt_pick = step_t'($urandom_range(1, 8000)); holo_pick = 1'($urandom); end
        3:       begin dt_pick = 16'h0001; holo_pick = 1'b1; end
        default: begin dt_pick = step_t'($urandom); holo_pick = 1'b0; end
      endcase
      program_register(REG_HOLONOMIC, 16'($urandom & 32'hFFFE) | 16'(holo_pick));
      program_register(REG_STEP_TIME, dt_pick);
      queued = 0;
      while (queued < 96) begin
        pending_steps.push_back(random_step(1'b1));
        queued++;
        repeat ($urandom_range(0, 15)) begin
          pending_steps.push_back(random_step(1'b0));
          queued++;
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("planar_pose_dead_reckoning_tb: PASS");
    end else begin
      $display("planar_pose_dead_reckoning_tb: FAIL");
    end
    $finish;
  end

endmodule

### planar_pose_dead_reckoning.f
src/ppdr_pkg.sv
src/ppdr_in_if.sv
src/ppdr_out_if.sv
src/planar_pose_dead_reckoning.sv
bench/planar_pose_dead_reckoning_tb.sv
